FILE: rtl/core/tga_truecolor_stream_decoder_defines.svh
// Assertion macros shared by the TGA stream decoder RTL.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef TGA_TRUECOLOR_STREAM_DECODER_DEFINES_SVH
`define TGA_TRUECOLOR_STREAM_DECODER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define TGA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its trigger.
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tga_pkg.sv
// Shared types and constants for the TGA truecolor stream decoder.
// Used by the parser, the result queue and the top level; no dependencies.
`timescale 1ns / 1ps

package tga_pkg;

	// Header layout
	localparam int HdrLen = 18;
	localparam int IdxW = 5;
	localparam logic [IdxW-1:0] HdrLastIdx = IdxW'(HdrLen - 1);

	localparam logic [7:0] ImgTypeTruecolor = 8'd2;
	localparam logic [7:0] Depth24 = 8'd24;
	localparam logic [7:0] Depth32 = 8'd32;

	// Result queue geometry
	localparam int QDepth = 4;
	localparam int QPtrW = 2;
	localparam int QCntW = 3;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE      = 4'd0,
		ERR_SHORT     = 4'd1,
		ERR_NO_IMAGE  = 4'd2,
		ERR_ID        = 4'd3,
		ERR_COLORMAP  = 4'd4,
		ERR_ORIGIN    = 4'd5,
		ERR_TYPE      = 4'd6,
		ERR_DEPTH     = 4'd7,
		ERR_TRUNCATED = 4'd8
	} err_t;

	typedef struct packed {
		kind_t       kind;
		err_t        error_code;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        has_alpha;
		logic        last_pixel;
	} result_t;

	// Results produced by one byte: the second is only used with the first.
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// Queue status seen by the input side.
	typedef struct packed {
		logic [QCntW-1:0] count;
		logic             room_for_two;
	} qstat_t;

endpackage

FILE: rtl/core/tga_parse.sv
// Byte parser: header capture and checks, pixel assembly and counting.
// Depends on tga_pkg; produces up to two results per parsed byte.
`timescale 1ns / 1ps

module tga_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_s1,
	input  logic              eof_s1,
	output tga_pkg::push_t    push,
	output tga_pkg::result_t  res0,
	output tga_pkg::result_t  res1
);

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_PIXELS = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [tga_pkg::IdxW-1:0]   idx_q, idx_d;
	logic [7:0]                 hdr_q [tga_pkg::HdrLen];
	logic [23:0]                pix_q;
	logic [1:0]                 pos_q, pos_d;
	logic [31:0]                left_q, left_d;

	logic [15:0]                width, height;
	logic [31:0]                area;
	logic                       is32;
	logic                       px_done;
	logic                       px_last;
	tga_pkg::err_t              hdr_err;
	tga_pkg::result_t           trunc_res;

	// Header fields from the captured bytes (little endian).
	assign width  = {hdr_q[13], hdr_q[12]};
	assign height = {hdr_q[15], hdr_q[14]};
	assign area   = width * height;
	assign is32   = (hdr_q[16] == tga_pkg::Depth32);

	// Header checks in order of priority; the descriptor byte is not examined.
	always_comb begin
		if (hdr_q[2] == 8'd0) begin
			hdr_err = tga_pkg::ERR_NO_IMAGE;
		end else if (hdr_q[0] != 8'd0) begin
			hdr_err = tga_pkg::ERR_ID;
		end else if ((hdr_q[1] | hdr_q[3] | hdr_q[4] | hdr_q[5] | hdr_q[6]) != 8'd0) begin
			hdr_err = tga_pkg::ERR_COLORMAP;
		end else if ((hdr_q[8] | hdr_q[9] | hdr_q[10] | hdr_q[11]) != 8'd0) begin
			hdr_err = tga_pkg::ERR_ORIGIN;
		end else if (hdr_q[2] != tga_pkg::ImgTypeTruecolor) begin
			hdr_err = tga_pkg::ERR_TYPE;
		end else if (hdr_q[16] != tga_pkg::Depth24 && hdr_q[16] != tga_pkg::Depth32) begin
			hdr_err = tga_pkg::ERR_DEPTH;
		end else begin
			hdr_err = tga_pkg::ERR_NONE;
		end
	end

	// Pixel completion depends on bytes per pixel.
	assign px_done = is32 ? (pos_q == 2'd3) : (pos_q == 2'd2);
	assign px_last = (left_q == 32'd1);

	always_comb begin
		trunc_res            = '0;
		trunc_res.kind       = tga_pkg::KIND_ERROR;
		trunc_res.error_code = tga_pkg::ERR_TRUNCATED;
	end

	// Next state and results for the byte being parsed.
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		left_d  = left_q;
		push    = '0;
		res0    = '0;
		res1    = trunc_res;
		if (take) begin
			case (phase_q)
				PH_HEADER: begin
					idx_d = idx_q + 1'b1;
					if (idx_q == tga_pkg::HdrLastIdx) begin
						push.first = 1'b1;
						if (hdr_err != tga_pkg::ERR_NONE) begin
							res0.kind       = tga_pkg::KIND_ERROR;
							res0.error_code = hdr_err;
							phase_d         = PH_DONE;
						end else begin
							res0.kind         = tga_pkg::KIND_HEADER;
							res0.image_width  = width;
							res0.image_height = height;
							res0.has_alpha    = is32;
							left_d            = area;
							pos_d             = 2'd0;
							if (width != 16'd0 && height != 16'd0) begin
								phase_d     = PH_PIXELS;
								push.second = eof_s1;
							end else begin
								phase_d = PH_DONE;
							end
						end
					end else if (eof_s1) begin
						push.first      = 1'b1;
						res0.kind       = tga_pkg::KIND_ERROR;
						res0.error_code = tga_pkg::ERR_SHORT;
					end
				end
				PH_PIXELS: begin
					pos_d = pos_q + 1'b1;
					if (px_done) begin
						push.first      = 1'b1;
						res0.kind       = tga_pkg::KIND_PIXEL;
						res0.blue       = pix_q[7:0];
						res0.green      = pix_q[15:8];
						res0.red        = (pos_q == 2'd2) ? data_s1 : pix_q[23:16];
						res0.alpha      = is32 ? data_s1 : 8'd0;
						res0.has_alpha  = is32;
						res0.last_pixel = px_last;
						left_d          = left_q - 32'd1;
						pos_d           = 2'd0;
						if (px_last) begin
							phase_d = PH_DONE;
						end else begin
							push.second = eof_s1;
						end
					end else if (eof_s1) begin
						push.first = 1'b1;
						res0       = trunc_res;
					end
				end
				default: begin
				end
			endcase
			// The last byte of a file restarts the parser for the next one.
			if (eof_s1) begin
				phase_d = PH_HEADER;
				idx_d   = '0;
				pos_d   = 2'd0;
				left_d  = 32'd0;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			pos_q   <= 2'd0;
			left_q  <= 32'd0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			pos_q   <= pos_d;
			left_q  <= left_d;
		end
	end

	// Header byte capture and pixel byte capture.
	always_ff @(posedge clk) begin
		for (int i = 0; i < tga_pkg::HdrLen; i++) begin
			if (take && phase_q == PH_HEADER && idx_q == tga_pkg::IdxW'(i)) begin
				hdr_q[i] <= data_s1;
			end
		end
		if (take && phase_q == PH_PIXELS) begin
			case (pos_q)
				2'd0: pix_q[7:0] <= data_s1;
				2'd1: pix_q[15:8] <= data_s1;
				2'd2: pix_q[23:16] <= data_s1;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/tga_resq.sv
// Result queue: takes up to two results per cycle and hands out one.
// Depends on tga_pkg; its registered head drives the result channel.
`timescale 1ns / 1ps

module tga_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  tga_pkg::push_t    push,
	input  tga_pkg::result_t  res0,
	input  tga_pkg::result_t  res1,
	input  logic              pop,
	output tga_pkg::result_t  head,
	output logic              head_valid,
	output tga_pkg::qstat_t   stat
);

	tga_pkg::result_t               mem_q [tga_pkg::QDepth];
	logic [tga_pkg::QPtrW-1:0]      wr_q, rd_q;
	logic [tga_pkg::QCntW-1:0]      cnt_q;
	logic [tga_pkg::QPtrW-1:0]      wr_next;
	logic [tga_pkg::QCntW-1:0]      n_push;

	assign wr_next = wr_q + 1'b1;
	assign n_push  = tga_pkg::QCntW'(push.first) + tga_pkg::QCntW'(push.second);

	assign head              = mem_q[rd_q];
	assign head_valid        = (cnt_q != '0);
	assign stat.count        = cnt_q;
	assign stat.room_for_two = (cnt_q <= tga_pkg::QCntW'(tga_pkg::QDepth - 2));

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + tga_pkg::QPtrW'(n_push);
			rd_q  <= rd_q + tga_pkg::QPtrW'(pop);
			cnt_q <= cnt_q + n_push - tga_pkg::QCntW'(pop);
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_q] <= res0;
		end
		if (push.second) begin
			mem_q[wr_next] <= res1;
		end
	end

endmodule

FILE: rtl/core/tga_truecolor_stream_decoder.sv
// Top level of the TGA truecolor stream decoder.
// Depends on tga_pkg, tga_parse, tga_resq and the assertion macro header.
//
// Usage:
//   Byte channel: data_byte with end_of_file, qualified by byte_valid and
//   held off by byte_stall. end_of_file marks the last byte of a file; the
//   next byte starts a new file at its header.
//   Result channel: kind, error_code, image_width, image_height, red, green,
//   blue, alpha, has_alpha and last_pixel, qualified by result_valid and
//   held off by result_stall. A byte yields zero, one or two results.
// Path: an accepted byte waits in the input register until the queue has room
//   for two; the parser then writes its results into the queue, in order.
// Throughput: one byte per cycle while byte_stall is low. A byte leaves the
//   input register when the four-entry result queue has room for two
//   results, so byte_stall rises only when three or more results wait,
//   which happens only while the receiver stalls.
// Reset: arst_n clears the input register, the parser state and the queue;
//   the decoder then expects the first header byte.
// Stall: while result_stall is high the head result holds, results collect
//   in the queue and then the byte channel stalls.
`timescale 1ns / 1ps
`include "tga_truecolor_stream_decoder_defines.svh"

module tga_truecolor_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [3:0]  error_code,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        has_alpha,
	output logic        last_pixel
);

	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               eof_s1;
	logic               take;
	tga_pkg::push_t     push;
	tga_pkg::result_t   res0, res1, head;
	tga_pkg::qstat_t    qstat;

	// The input register moves on only when the queue can absorb two results.
	assign take       = valid_s1 && qstat.room_for_two;
	assign byte_stall = valid_s1 && !qstat.room_for_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	tga_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.data_s1 (data_s1),
		.eof_s1  (eof_s1),
		.push    (push),
		.res0    (res0),
		.res1    (res1)
	);

	tga_resq u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.res0       (res0),
		.res1       (res1),
		.pop        (result_valid && !result_stall),
		.head       (head),
		.head_valid (result_valid),
		.stat       (qstat)
	);

	// Result fields from the queue head.
	assign kind         = head.kind;
	assign error_code   = head.error_code;
	assign image_width  = head.image_width;
	assign image_height = head.image_height;
	assign red          = head.red;
	assign green        = head.green;
	assign blue         = head.blue;
	assign alpha        = head.alpha;
	assign has_alpha    = head.has_alpha;
	assign last_pixel   = head.last_pixel;

	// Checks on queue occupancy and on the results a byte produces.
	`TGA_ASSERT_SAME(a_queue_bound, 1'b1, qstat.count <= 3'd4, "result queue overfilled")
	`TGA_ASSERT_SAME(a_second_is_trunc, push.second, push.first && take && res1.kind == tga_pkg::KIND_ERROR && res1.error_code == tga_pkg::ERR_TRUNCATED, "bad second result")
	`TGA_ASSERT_NEXT(a_push_shows, push.first, result_valid, "pushed result not offered")

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the TGA truecolor stream decoder.
// Depends on tga_pkg and the tga_truecolor_stream_decoder RTL.
// Drives byte files and compares each result with a local decoder model or a hand-written result.
`timescale 1ns / 1ps

module tb;

	// One planned byte transaction, with a hand-written result where the row has one.
	typedef struct packed {
		logic [7:0]       data;
		logic             eof;
		logic             typed;
		tga_pkg::result_t want;
	} byte_txn_t;

	typedef enum logic [1:0] {
		DEC_HEADER,
		DEC_PIXELS,
		DEC_DONE
	} dec_phase_t;

	localparam int TargetBytes = 1000;

	localparam logic [7:0] DirHeader [tga_pkg::HdrLen] = '{
		8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00, 8'h20, 8'h28
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_file = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  error_code;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        has_alpha;
	logic        last_pixel;

	byte_txn_t        byte_plan [$];
	byte_txn_t        cur_txn = '0;
	tga_pkg::result_t pending_results [$];
	int               useful_bytes = 0;
	int               mismatch_count = 0;
	int               idle_mode = 0;

	// Decoder model state, at its reset values.
	logic [4:0]  hdr_cnt = '0;
	logic [7:0]  hdr_store [tga_pkg::HdrLen];
	dec_phase_t  dec_phase = DEC_HEADER;
	logic [23:0] pix_acc = '0;
	logic [1:0]  pix_pos = '0;
	logic [31:0] pix_remaining = '0;

	tga_truecolor_stream_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.end_of_file  (end_of_file),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.error_code   (error_code),
		.image_width  (image_width),
		.image_height (image_height),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.has_alpha    (has_alpha),
		.last_pixel   (last_pixel)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic tga_pkg::result_t mk_result(input tga_pkg::kind_t k,
			input tga_pkg::err_t e,
			input logic [15:0] w, input logic [15:0] h, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] a,
			input logic ha, input logic last);
		tga_pkg::result_t res;
		res.kind = k;
		res.error_code = e;
		res.image_width = w;
		res.image_height = h;
		res.red = r;
		res.green = g;
		res.blue = b;
		res.alpha = a;
		res.has_alpha = ha;
		res.last_pixel = last;
		return res;
	endfunction

	function automatic tga_pkg::result_t err_result(input tga_pkg::err_t e);
		return mk_result(tga_pkg::KIND_ERROR, e, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0,
			1'b0, 1'b0);
	endfunction

	// Little-endian 16-bit header field.
	function automatic logic [15:0] hdr_word(input int pos);
		return {hdr_store[pos + 1], hdr_store[pos]};
	endfunction

	// Header checks, in order of priority; the first that fails gives the error.
	function automatic tga_pkg::err_t header_fault();
		if (hdr_store[2] == 8'h00) return tga_pkg::ERR_NO_IMAGE;
		if (hdr_store[0] != 8'h00) return tga_pkg::ERR_ID;
		if (hdr_store[1] != 8'h00 || hdr_word(3) != 16'h0 || hdr_word(5) != 16'h0)
			return tga_pkg::ERR_COLORMAP;
		if (hdr_word(8) != 16'h0 || hdr_word(10) != 16'h0) return tga_pkg::ERR_ORIGIN;
		if (hdr_store[2] != tga_pkg::ImgTypeTruecolor) return tga_pkg::ERR_TYPE;
		if (hdr_store[16] != tga_pkg::Depth24 && hdr_store[16] != tga_pkg::Depth32)
			return tga_pkg::ERR_DEPTH;
		return tga_pkg::ERR_NONE;
	endfunction

	// Advances the decoder model by one byte and queues the results it causes.
	task automatic decode_byte(input logic [7:0] b, input logic eof);
		tga_pkg::err_t fault;
		logic alpha_img;
		int   need;
		int   p;
		if (dec_phase == DEC_HEADER) begin
			if (hdr_cnt < tga_pkg::HdrLen) begin
				hdr_store[hdr_cnt] = b;
				hdr_cnt = hdr_cnt + 5'd1;
			end
			if (hdr_cnt >= tga_pkg::HdrLen) begin
				fault = header_fault();
				if (fault != tga_pkg::ERR_NONE) begin
					pending_results.push_back(err_result(fault));
					dec_phase = DEC_DONE;
				end else begin
					pending_results.push_back(mk_result(tga_pkg::KIND_HEADER,
						tga_pkg::ERR_NONE, hdr_word(12), hdr_word(14), 8'h0, 8'h0,
						8'h0, 8'h0, hdr_store[16] == tga_pkg::Depth32, 1'b0));
					pix_remaining = 32'(hdr_word(12)) * 32'(hdr_word(14));
					pix_acc = '0;
					pix_pos = '0;
					dec_phase = (pix_remaining != 0) ? DEC_PIXELS : DEC_DONE;
					if (eof && pix_remaining != 0)
						pending_results.push_back(err_result(tga_pkg::ERR_TRUNCATED));
				end
			end else if (eof) begin
				pending_results.push_back(err_result(tga_pkg::ERR_SHORT));
			end
		end else if (dec_phase == DEC_PIXELS) begin
			// Stored order is B, G, R and then A for 32-bit images.
			alpha_img = (hdr_store[16] == tga_pkg::Depth32);
			need = alpha_img ? 4 : 3;
			p = int'(pix_pos);
			if (p < 3)
				pix_acc[8 * p +: 8] = b;
			pix_pos = pix_pos + 2'd1;
			if (p + 1 >= need) begin
				pix_remaining = pix_remaining - 32'd1;
				pending_results.push_back(mk_result(tga_pkg::KIND_PIXEL, tga_pkg::ERR_NONE,
					16'h0, 16'h0, pix_acc[23:16], pix_acc[15:8], pix_acc[7:0],
					alpha_img ? b : 8'h00, alpha_img, pix_remaining == 0));
				pix_pos = '0;
				pix_acc = '0;
				if (pix_remaining == 0)
					dec_phase = DEC_DONE;
			end
			if (eof && dec_phase == DEC_PIXELS)
				pending_results.push_back(err_result(tga_pkg::ERR_TRUNCATED));
		end
		// The end-of-file byte always starts a fresh file.
		if (eof) begin
			hdr_cnt = '0;
			dec_phase = DEC_HEADER;
			pix_acc = '0;
			pix_pos = '0;
			pix_remaining = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
	endtask

	task automatic add_byte(input logic [7:0] d, input logic eof, input logic typed,
			input tga_pkg::result_t want, input logic useful);
		byte_txn_t txn;
		txn.data = d;
		txn.eof = eof;
		txn.typed = typed;
		txn.want = want;
		byte_plan.push_back(txn);
		if (useful)
			useful_bytes++;
	endtask

	// Directed table: short files, a 32-bit header, a pixel with extreme bytes
	// and a file cut off inside its second pixel.
	task automatic build_directed();
		int i;
		add_byte(8'hFF, 1'b1, 1'b1, err_result(tga_pkg::ERR_SHORT), 1'b1);
		for (i = 0; i < tga_pkg::HdrLen - 1; i++)
			add_byte(DirHeader[i], 1'b0, 1'b0, '0, 1'b1);
		add_byte(DirHeader[tga_pkg::HdrLen - 1], 1'b0, 1'b1,
			mk_result(tga_pkg::KIND_HEADER, tga_pkg::ERR_NONE, 16'd2, 16'd1,
			8'h0, 8'h0, 8'h0, 8'h0, 1'b1, 1'b0), 1'b1);
		add_byte(8'h00, 1'b0, 1'b0, '0, 1'b1);
		add_byte(8'hFF, 1'b0, 1'b0, '0, 1'b1);
		add_byte(8'h80, 1'b0, 1'b0, '0, 1'b1);
		add_byte(8'hFF, 1'b0, 1'b0, '0, 1'b1);
		add_byte(8'h55, 1'b0, 1'b0, '0, 1'b1);
		add_byte(8'hAA, 1'b1, 1'b1, err_result(tga_pkg::ERR_TRUNCATED), 1'b1);
		add_byte(8'h00, 1'b1, 1'b1, err_result(tga_pkg::ERR_SHORT), 1'b1);
	endtask

	// One random file: mostly well-formed, the rest bad headers, short files and noise.
	task automatic make_file();
		logic [7:0] hb [tga_pkg::HdrLen];
		int pick, w, h, total, body, extra, hlen, faults, sel, k, i, n;
		pick = $urandom_range(0, 99);
		for (i = 0; i < tga_pkg::HdrLen; i++)
			hb[i] = 8'h00;
		hb[2] = tga_pkg::ImgTypeTruecolor;
		hb[16] = $urandom_range(0, 1) ? tga_pkg::Depth32 : tga_pkg::Depth24;
		hb[17] = 8'($urandom);
		if ($urandom_range(0, 19) == 0) begin
			// Empty image with one dimension at its maximum.
			w = $urandom_range(0, 1) ? 65535 : 0;
			h = (w == 0) ? 65535 : 0;
		end else begin
			w = $urandom_range(0, 6);
			h = $urandom_range(0, 6);
		end
		hb[12] = w[7:0];
		hb[13] = w[15:8];
		hb[14] = h[7:0];
		hb[15] = h[15:8];
		total = w * h * ((hb[16] == tga_pkg::Depth32) ? 4 : 3);
		hlen = tga_pkg::HdrLen;
		body = 0;
		extra = 0;
		if (pick < 60) begin
			sel = $urandom_range(0, 9);
			body = total;
			if (sel >= 8)
				body = (total > 0) ? $urandom_range(0, total - 1) : 0;
			else if (sel >= 6)
				extra = $urandom_range(1, 4);
		end else if (pick < 80) begin
			faults = $urandom_range(1, 2);
			repeat (faults) begin
				sel = $urandom_range(0, 5);
				k = $urandom_range(1, 254);
				case (sel)
					0: hb[2] = 8'h00;
					1: hb[0] = 8'(k);
					2: hb[($urandom_range(0, 5) == 0) ? 1 : $urandom_range(3, 7)] = 8'(k);
					3: hb[$urandom_range(8, 11)] = 8'(k);
					4: hb[2] = (k >= 2) ? 8'(k + 1) : 8'(k);
					default: hb[16] = (8'(k) == tga_pkg::Depth24 || 8'(k) == tga_pkg::Depth32) ?
						8'(k + 1) : 8'(k);
				endcase
			end
			extra = $urandom_range(0, 3);
		end else if (pick < 90) begin
			hlen = $urandom_range(1, tga_pkg::HdrLen - 1);
		end else begin
			for (i = 0; i < tga_pkg::HdrLen; i++)
				hb[i] = 8'($urandom);
			extra = $urandom_range(0, 12);
		end
		n = hlen + body + extra;
		for (i = 0; i < n; i++)
			add_byte((i < hlen) ? hb[i] : 8'($urandom), i == n - 1, 1'b0, '0, i < hlen + body);
	endtask

	// Result side: random stall by idling phase.
	always @(posedge clk) begin
		result_stall <= (idle_mode == 2) ? ($urandom_range(0, 99) < 45) :
			(idle_mode == 3) ? ($urandom_range(0, 99) < 25) : 1'b0;
	end

	// Predicts on accepted bytes and checks accepted results, in one process.
	always @(posedge clk) begin : check_proc
		tga_pkg::result_t want;
		int n0;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				n0 = pending_results.size();
				decode_byte(data_byte, end_of_file);
				if (cur_txn.typed) begin
					while (pending_results.size() > n0)
						void'(pending_results.pop_back());
					pending_results.push_back(cur_txn.want);
				end
			end
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing expected, kind", kind, 0);
				end else begin
					want = pending_results.pop_front();
					if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
					if (error_code !== want.error_code)
						report_mismatch("error_code", error_code, want.error_code);
					if (image_width !== want.image_width)
						report_mismatch("image_width", image_width, want.image_width);
					if (image_height !== want.image_height)
						report_mismatch("image_height", image_height, want.image_height);
					if (red !== want.red) report_mismatch("red", red, want.red);
					if (green !== want.green) report_mismatch("green", green, want.green);
					if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
					if (alpha !== want.alpha) report_mismatch("alpha", alpha, want.alpha);
					if (has_alpha !== want.has_alpha)
						report_mismatch("has_alpha", has_alpha, want.has_alpha);
					if (last_pixel !== want.last_pixel)
						report_mismatch("last_pixel", last_pixel, want.last_pixel);
				end
			end
		end
	end

	// Byte side: reset, then every planned transaction, then the drain.
	initial begin
		int sent;
		int total;
		int idle_pct;
		build_directed();
		while (useful_bytes < TargetBytes)
			make_file();
		total = byte_plan.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		sent = 0;
		while (sent < total) begin
			@(posedge clk);
			if (byte_valid && !byte_stall)
				sent++;
			idle_mode = sent * 4 / total;
			idle_pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 25 : 0;
			// A stalled transaction holds; otherwise offer the next one or idle.
			if (!(byte_valid && byte_stall)) begin
				if (sent < total && $urandom_range(0, 99) >= idle_pct) begin
					byte_valid <= 1'b1;
					data_byte <= byte_plan[sent].data;
					end_of_file <= byte_plan[sent].eof;
					cur_txn <= byte_plan[sent];
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("TIMEOUT with %0d results still expected", pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
